[hw/rtl/fwrl_pkg.sv]
// ----------------------------------------------------------------------------
// Fixed-window rate limiter package
// Shared types, register indexes, request codes and reset constants.
// ----------------------------------------------------------------------------
package fwrl_pkg;

	localparam int METHOD_SLOTS_DEF = 64;
	localparam int CLIENT_SLOTS_DEF = 16;

	localparam int METHOD_SLOT_W = 6;
	localparam int CLIENT_SLOT_W = 4;
	localparam int REQ_TYPE_W = 3;
	localparam int COUNT_W = 16;
	localparam int TIME_W = 32;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [COUNT_W-1:0] DEFAULT_MAX_RST = COUNT_W'(100);
	localparam logic [TIME_W-1:0] DEFAULT_WINDOW_RST = TIME_W'(60);
	localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

	typedef enum logic [REQ_TYPE_W-1:0] {
		REQ_CHECK = 3'd0,
		REQ_RECORD = 3'd1,
		REQ_RESET_ENTRY = 3'd2,
		REQ_CLEAR_ALL = 3'd3,
		REQ_SET_METHOD = 3'd4,
		REQ_SET_CLIENT = 3'd5
	} req_code_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_ENABLED = 2'd0,
		CFG_DEFAULT_MAX = 2'd1,
		CFG_DEFAULT_WINDOW = 2'd2
	} cfg_index_t;

	typedef enum logic [2:0] {
		SW_IDLE = 3'b001,
		SW_ALL = 3'b010,
		SW_ENTRY = 3'b100
	} sweep_state_t;

	typedef struct packed {
		logic [REQ_TYPE_W-1:0] req_type;
		logic [METHOD_SLOT_W-1:0] method_slot;
		logic [CLIENT_SLOT_W-1:0] client_slot;
		logic [TIME_W-1:0] now_seconds;
		logic [COUNT_W-1:0] new_max;
		logic [TIME_W-1:0] new_window;
	} req_t;

	typedef struct packed {
		logic allowed;
		logic [COUNT_W-1:0] count_now;
		logic not_running;
	} rsp_t;

	typedef struct packed {
		logic enabled;
		logic [COUNT_W-1:0] default_max;
		logic [TIME_W-1:0] default_window;
	} cfg_t;

	typedef struct packed {
		logic used;
		logic [COUNT_W-1:0] count;
		logic [TIME_W-1:0] win_start;
	} entry_word_t;

	typedef struct packed {
		logic set;
		logic [COUNT_W-1:0] max_req;
		logic [TIME_W-1:0] win_len;
	} limit_word_t;

	typedef struct packed {
		logic entry_we;
		logic meth_we;
		logic cli_we;
		logic clear_start;
	} upd_ctl_t;

	typedef struct packed {
		logic busy;
		logic all;
	} sweep_t;

endpackage

[hw/rtl/fwrl_ram.sv]
// ----------------------------------------------------------------------------
// Fixed-window rate limiter RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fwrl_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 49,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic clk,
	input  logic we,
	input  logic [AW-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/fwrl_sweep.sv]
// ----------------------------------------------------------------------------
// Fixed-window rate limiter clearing sequencer
// Walks every entry address once after reset (also clearing the limit tables)
// and once for each clear-all request (entries only).
// ----------------------------------------------------------------------------
module fwrl_sweep #(
	parameter int DEPTH = 1024,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output fwrl_pkg::sweep_t sweep,
	output logic [AW-1:0] addr
);

	fwrl_pkg::sweep_state_t state_q;
	logic [AW-1:0] addr_q;
	logic last;

	assign last = (addr_q == AW'(DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fwrl_pkg::SW_ALL;
			addr_q <= '0;
		end else begin
			unique case (state_q)
				fwrl_pkg::SW_IDLE: begin
					addr_q <= '0;
					if (start) begin
						state_q <= fwrl_pkg::SW_ENTRY;
					end
				end
				fwrl_pkg::SW_ALL, fwrl_pkg::SW_ENTRY: begin
					if (last) begin
						state_q <= fwrl_pkg::SW_IDLE;
						addr_q <= '0;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				default: begin
					state_q <= fwrl_pkg::SW_IDLE;
				end
			endcase
		end
	end

	assign sweep.busy = (state_q != fwrl_pkg::SW_IDLE);
	assign sweep.all = (state_q == fwrl_pkg::SW_ALL);
	assign addr = addr_q;

endmodule

[hw/rtl/fwrl_update.sv]
// ----------------------------------------------------------------------------
// Fixed-window rate limiter update logic
// Chooses the limit, restarts stale windows, updates the count and builds
// the response and the write-back words for one request.
// ----------------------------------------------------------------------------
module fwrl_update (
	input  fwrl_pkg::req_t req,
	input  fwrl_pkg::cfg_t cfg,
	input  fwrl_pkg::entry_word_t entry,
	input  fwrl_pkg::limit_word_t meth,
	input  fwrl_pkg::limit_word_t cli,
	output fwrl_pkg::upd_ctl_t ctl,
	output fwrl_pkg::entry_word_t entry_wdata,
	output fwrl_pkg::limit_word_t limit_wdata,
	output fwrl_pkg::rsp_t rsp
);

	logic [fwrl_pkg::COUNT_W-1:0] lim_max;
	logic [fwrl_pkg::TIME_W-1:0] lim_win;
	logic [fwrl_pkg::TIME_W-1:0] age;
	logic stale;
	logic [fwrl_pkg::COUNT_W-1:0] base;
	logic [fwrl_pkg::COUNT_W-1:0] next_count;

	always_comb begin
		priority if (meth.set) begin
			lim_max = meth.max_req;
			lim_win = meth.win_len;
		end else if (cli.set) begin
			lim_max = cli.max_req;
			lim_win = cli.win_len;
		end else begin
			lim_max = cfg.default_max;
			lim_win = cfg.default_window;
		end
	end

	assign age = req.now_seconds - entry.win_start;
	assign stale = !entry.used || (age > lim_win);
	assign base = stale ? '0 : entry.count;

	always_comb begin
		next_count = base;
		if ((req.req_type == fwrl_pkg::REQ_RECORD) && (base != fwrl_pkg::COUNT_SAT)) begin
			next_count = base + fwrl_pkg::COUNT_W'(1);
		end
	end

	assign limit_wdata.set = 1'b1;
	assign limit_wdata.max_req = req.new_max;
	assign limit_wdata.win_len = req.new_window;

	always_comb begin
		ctl = '0;
		rsp = '0;
		entry_wdata = '0;
		if (!cfg.enabled) begin
			rsp.not_running = 1'b1;
		end else begin
			unique case (req.req_type)
				fwrl_pkg::REQ_CHECK, fwrl_pkg::REQ_RECORD: begin
					ctl.entry_we = 1'b1;
					entry_wdata.used = 1'b1;
					entry_wdata.count = next_count;
					entry_wdata.win_start = stale ? req.now_seconds : entry.win_start;
					rsp.allowed = (base < lim_max);
					rsp.count_now = next_count;
				end
				fwrl_pkg::REQ_RESET_ENTRY: begin
					ctl.entry_we = 1'b1;
				end
				fwrl_pkg::REQ_CLEAR_ALL: begin
					ctl.clear_start = 1'b1;
				end
				fwrl_pkg::REQ_SET_METHOD: begin
					ctl.meth_we = 1'b1;
				end
				fwrl_pkg::REQ_SET_CLIENT: begin
					ctl.cli_we = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[hw/rtl/fixed_window_rate_limiter_unit.sv]
// ----------------------------------------------------------------------------
// Fixed-window rate limiter unit
// Per client and method request counters with fixed windows, held in RAM.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_ready as one transaction each and every
// request produces exactly one response transaction on out_valid/out_ready.
// A request is looked up in the entry, method-limit and client-limit RAMs
// in the cycle it is accepted; the lookup stage then computes the update,
// writes it back and loads the output register. One request per cycle is
// sustained while out_ready is high and no clear is under way; a write-back that
// hits the entry or limit slot read by the following request is forwarded.
// A clear-all request, when the limiter is enabled, starts a pass over all
// CLIENT_SLOTS*METHOD_SLOTS entries, one per cycle, and in_ready stays low
// until the pass ends. After reset the same pass runs once, also clearing
// the limit tables, so in_ready rises only once that pass is over.
// When out_ready is low the response waits in the output register; one more
// request may be held in the lookup stage and then in_ready drops.
// Configuration writes on cfg_we take effect at once; the user must make them
// only while no request is in flight, as the block does not enforce this.
// ----------------------------------------------------------------------------
module fixed_window_rate_limiter_unit #(
	parameter int METHOD_SLOTS = fwrl_pkg::METHOD_SLOTS_DEF,
	parameter int CLIENT_SLOTS = fwrl_pkg::CLIENT_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  fwrl_pkg::req_t in_item,
	output logic out_valid,
	input  logic out_ready,
	output fwrl_pkg::rsp_t out_item,
	input  logic cfg_we,
	input  logic [fwrl_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [fwrl_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int ENTRY_SLOTS = METHOD_SLOTS * CLIENT_SLOTS;
	localparam int MW = (METHOD_SLOTS > 1) ? $clog2(METHOD_SLOTS) : 1;
	localparam int CW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
	localparam int EW = (ENTRY_SLOTS > 1) ? $clog2(ENTRY_SLOTS) : 1;
	localparam int ENTRY_BITS = $bits(fwrl_pkg::entry_word_t);
	localparam int LIMIT_BITS = $bits(fwrl_pkg::limit_word_t);
	localparam int MSLOT_N = 1 << fwrl_pkg::METHOD_SLOT_W;
	localparam int CSLOT_N = 1 << fwrl_pkg::CLIENT_SLOT_W;

	fwrl_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled <= 1'b0;
			cfg_q.default_max <= fwrl_pkg::DEFAULT_MAX_RST;
			cfg_q.default_window <= fwrl_pkg::DEFAULT_WINDOW_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fwrl_pkg::CFG_ENABLED: cfg_q.enabled <= cfg_data[0];
				fwrl_pkg::CFG_DEFAULT_MAX: cfg_q.default_max <= cfg_data[fwrl_pkg::COUNT_W-1:0];
				fwrl_pkg::CFG_DEFAULT_WINDOW: cfg_q.default_window <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	logic [MW-1:0] m_map [MSLOT_N];
	logic [CW-1:0] c_map [CSLOT_N];

	for (genvar g = 0; g < MSLOT_N; g++) begin : g_mmap
		assign m_map[g] = MW'(g % METHOD_SLOTS);
	end
	for (genvar g = 0; g < CSLOT_N; g++) begin : g_cmap
		assign c_map[g] = CW'(g % CLIENT_SLOTS);
	end

	logic [MW-1:0] m_in;
	logic [CW-1:0] c_in;
	logic [EW-1:0] e_in;

	assign m_in = m_map[in_item.method_slot];
	assign c_in = c_map[in_item.client_slot];
	assign e_in = EW'(EW'(c_in) * EW'(METHOD_SLOTS)) + EW'(m_in);

	logic accept;
	logic valid_s1;
	logic adv_s1;
	fwrl_pkg::req_t req_s1;
	logic [MW-1:0] m_s1;
	logic [CW-1:0] c_s1;
	logic [EW-1:0] e_s1;
	logic ent_hit_s1;
	logic meth_hit_s1;
	logic cli_hit_s1;
	fwrl_pkg::entry_word_t ent_fwd_s1;
	fwrl_pkg::limit_word_t meth_fwd_s1;
	fwrl_pkg::limit_word_t cli_fwd_s1;

	logic out_valid_q;
	fwrl_pkg::rsp_t out_item_q;

	fwrl_pkg::sweep_t sweep;
	logic [EW-1:0] sweep_addr;
	logic sweep_start;

	fwrl_pkg::upd_ctl_t ctl;
	fwrl_pkg::entry_word_t upd_entry;
	fwrl_pkg::limit_word_t upd_limit;
	fwrl_pkg::rsp_t upd_rsp;

	logic [ENTRY_BITS-1:0] ent_rdata;
	logic [LIMIT_BITS-1:0] meth_rdata;
	logic [LIMIT_BITS-1:0] cli_rdata;
	fwrl_pkg::entry_word_t ent_cur;
	fwrl_pkg::limit_word_t meth_cur;
	fwrl_pkg::limit_word_t cli_cur;

	logic ent_we;
	logic [EW-1:0] ent_waddr;
	fwrl_pkg::entry_word_t ent_wdata;
	logic meth_we;
	logic [MW-1:0] meth_waddr;
	fwrl_pkg::limit_word_t meth_wdata;
	logic cli_we;
	logic [CW-1:0] cli_waddr;
	fwrl_pkg::limit_word_t cli_wdata;
	logic meth_in_range;
	logic cli_in_range;
	logic clear_in_s1;

	assign adv_s1 = valid_s1 && (!out_valid_q || out_ready);
	assign clear_in_s1 = valid_s1 && (req_s1.req_type == fwrl_pkg::REQ_CLEAR_ALL);
	assign in_ready = !sweep.busy && !clear_in_s1 && (!valid_s1 || adv_s1);
	assign accept = in_valid && in_ready;
	assign sweep_start = adv_s1 && ctl.clear_start;

	assign meth_in_range = ({1'b0, sweep_addr} < (EW + 1)'(METHOD_SLOTS));
	assign cli_in_range = ({1'b0, sweep_addr} < (EW + 1)'(CLIENT_SLOTS));

	always_comb begin
		if (sweep.busy) begin
			ent_we = 1'b1;
			ent_waddr = sweep_addr;
			ent_wdata = '0;
			meth_we = sweep.all && meth_in_range;
			meth_waddr = sweep_addr[MW-1:0];
			meth_wdata = '0;
			cli_we = sweep.all && cli_in_range;
			cli_waddr = sweep_addr[CW-1:0];
			cli_wdata = '0;
		end else begin
			ent_we = adv_s1 && ctl.entry_we;
			ent_waddr = e_s1;
			ent_wdata = upd_entry;
			meth_we = adv_s1 && ctl.meth_we;
			meth_waddr = m_s1;
			meth_wdata = upd_limit;
			cli_we = adv_s1 && ctl.cli_we;
			cli_waddr = c_s1;
			cli_wdata = upd_limit;
		end
	end

	fwrl_ram #(
		.DEPTH(ENTRY_SLOTS),
		.WIDTH(ENTRY_BITS),
		.AW(EW)
	) u_entry_ram (
		.clk(clk),
		.we(ent_we),
		.waddr(ent_waddr),
		.wdata(ent_wdata),
		.re(accept),
		.raddr(e_in),
		.rdata(ent_rdata)
	);

	fwrl_ram #(
		.DEPTH(METHOD_SLOTS),
		.WIDTH(LIMIT_BITS),
		.AW(MW)
	) u_method_ram (
		.clk(clk),
		.we(meth_we),
		.waddr(meth_waddr),
		.wdata(meth_wdata),
		.re(accept),
		.raddr(m_in),
		.rdata(meth_rdata)
	);

	fwrl_ram #(
		.DEPTH(CLIENT_SLOTS),
		.WIDTH(LIMIT_BITS),
		.AW(CW)
	) u_client_ram (
		.clk(clk),
		.we(cli_we),
		.waddr(cli_waddr),
		.wdata(cli_wdata),
		.re(accept),
		.raddr(c_in),
		.rdata(cli_rdata)
	);

	fwrl_sweep #(
		.DEPTH(ENTRY_SLOTS),
		.AW(EW)
	) u_sweep (
		.clk(clk),
		.arst_n(arst_n),
		.start(sweep_start),
		.sweep(sweep),
		.addr(sweep_addr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// The write-back of the request leaving stage one lands in the same
	// edge as the new lookup, so a matching slot takes the written word.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= in_item;
			m_s1 <= m_in;
			c_s1 <= c_in;
			e_s1 <= e_in;
			ent_hit_s1 <= ent_we && (ent_waddr == e_in);
			meth_hit_s1 <= meth_we && (meth_waddr == m_in);
			cli_hit_s1 <= cli_we && (cli_waddr == c_in);
			ent_fwd_s1 <= ent_wdata;
			meth_fwd_s1 <= meth_wdata;
			cli_fwd_s1 <= cli_wdata;
		end
	end

	assign ent_cur = ent_hit_s1 ? ent_fwd_s1 : fwrl_pkg::entry_word_t'(ent_rdata);
	assign meth_cur = meth_hit_s1 ? meth_fwd_s1 : fwrl_pkg::limit_word_t'(meth_rdata);
	assign cli_cur = cli_hit_s1 ? cli_fwd_s1 : fwrl_pkg::limit_word_t'(cli_rdata);

	fwrl_update u_update (
		.req(req_s1),
		.cfg(cfg_q),
		.entry(ent_cur),
		.meth(meth_cur),
		.cli(cli_cur),
		.ctl(ctl),
		.entry_wdata(upd_entry),
		.limit_wdata(upd_limit),
		.rsp(upd_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_item_q <= upd_rsp;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

	a_no_request_during_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sweep.busy |-> !valid_s1)
		else $error("request in flight while the clearing pass runs");

	a_advance_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> out_valid_q)
		else $error("response lost when the lookup stage advanced");

	a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && clear_in_s1 && cfg_q.enabled) |=> (sweep.busy && !sweep.all))
		else $error("clear-all transaction did not start the clearing pass");

endmodule
